@@ design/b2f_pkg.sv @@
// ----------------------------------------------------------------------------
// b2f_pkg
// Shared types, register codes and helpers for the base-to-flowgram encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b2f_pkg;

	localparam int CntW = 12;
	localparam int MaxRes = 4;

	localparam logic [7:0] NUC_CYCLE_RESET = 8'd147;
	localparam logic [14:0] SIGNAL_PER_BASE = 15'd100;
	localparam logic REG_NUC_CYCLE = 1'b0;

	typedef struct packed {
		logic [2:0] base;
		logic       last_of_read;
	} item_t;

	typedef struct packed {
		logic [CntW-1:0] flow_number;
		logic [1:0]      flow_nucleotide;
		logic [7:0]      base_count;
		logic [14:0]     flow_signal;
		logic            bad_base;
		logic            end_of_read;
	} result_t;

	typedef result_t [MaxRes-1:0] result_set_t;

	typedef struct packed {
		logic [1:0]      flow_position;
		logic [7:0]      run_length;
		logic [1:0]      run_nucleotide;
		logic            run_open;
		logic [CntW-1:0] flow_counter;
	} read_state_t;

	function automatic logic [1:0] order_code(input logic [7:0] order, input logic [1:0] pos);
		order_code = order[{pos, 1'b0} +: 2];
	endfunction

	function automatic result_t make_result(input logic [CntW-1:0] num, input logic [1:0] nuc,
			input logic [7:0] count, input logic bad, input logic last);
		result_t r;
		r.flow_number = num;
		r.flow_nucleotide = nuc;
		r.base_count = count;
		r.flow_signal = {7'd0, count} * SIGNAL_PER_BASE;
		r.bad_base = bad;
		r.end_of_read = last;
		make_result = r;
	endfunction

endpackage

`default_nettype wire

@@ design/base_to_flowgram_encoder.sv @@
// ----------------------------------------------------------------------------
// base_to_flowgram_encoder
// Turns a stream of read bases into flowgram results over a cyclic order of
// four flows.
// ----------------------------------------------------------------------------
// Each base is registered, then evaluated against the read state in one pass
// and its zero to four results are loaded into a four-entry result queue
// whose head drives the result port. A base with at most one result moves
// through the input register and then the queue head at one per cycle while
// the result port does not stall; one with more results stalls the input
// until the queue is down to its last, as the queue hands out one result
// transfer per cycle when not stalled. Write the flow cycle register only
// while no read is in flight. There is no clearing pass after reset.
`default_nettype none

module base_to_flowgram_encoder #(
	parameter int MAX_FLOWS = 4096
) (
	input  wire  logic             clk,
	input  wire  logic             arst_n,
	input  wire  logic             item_valid,
	output logic                   item_stall,
	input  wire  b2f_pkg::item_t   item,
	output logic                   result_valid,
	input  wire  logic             result_stall,
	output b2f_pkg::result_t       result,
	input  wire  logic             psel,
	input  wire  logic             penable,
	input  wire  logic             pwrite,
	input  wire  logic [2:0]       paddr,
	input  wire  logic [31:0]      pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [7:0]           nuc_cycle_q;
	b2f_pkg::item_t       item_s1;
	logic                 valid_s1;
	b2f_pkg::read_state_t state_q;
	b2f_pkg::read_state_t state_nxt;
	b2f_pkg::result_set_t res;
	logic [2:0]           res_cnt;
	logic                 load_ok;
	logic                 load;
	logic                 in_xfer;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == b2f_pkg::REG_NUC_CYCLE) ? {24'd0, nuc_cycle_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nuc_cycle_q <= b2f_pkg::NUC_CYCLE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == b2f_pkg::REG_NUC_CYCLE) begin
			nuc_cycle_q <= pwdata[7:0];
		end
	end

	assign load = valid_s1 && load_ok;
	assign item_stall = valid_s1 && !load_ok;
	assign in_xfer = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	b2f_calc #(
		.MAX_FLOWS(MAX_FLOWS)
	) u_calc (
		.nuc_cycle (nuc_cycle_q),
		.st        (state_q),
		.item      (item_s1),
		.nxt       (state_nxt),
		.res       (res),
		.res_cnt   (res_cnt)
	);

	b2f_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_res    (res),
		.load_cnt    (res_cnt),
		.load_ok     (load_ok),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire

@@ design/b2f_calc.sv @@
// ----------------------------------------------------------------------------
// b2f_calc
// Per-base flow logic: closes runs, emits skipped flows, errors and
// end-of-read results, and gives the read state that follows.
// ----------------------------------------------------------------------------
`default_nettype none

module b2f_calc #(
	parameter int MAX_FLOWS = 4096
) (
	input  wire  logic [7:0]           nuc_cycle,
	input  wire  b2f_pkg::read_state_t st,
	input  wire  b2f_pkg::item_t       item,
	output b2f_pkg::read_state_t       nxt,
	output b2f_pkg::result_set_t       res,
	output logic [2:0]                 res_cnt
);

	localparam int LimInt = (MAX_FLOWS - 1 > 4095) ? 4095 : MAX_FLOWS - 1;
	localparam logic [b2f_pkg::CntW-1:0] LIMIT = b2f_pkg::CntW'(LimInt);

	function automatic logic [b2f_pkg::CntW-1:0] adv(input logic [b2f_pkg::CntW-1:0] c);
		adv = (c < LIMIT) ? c + 1'b1 : c;
	endfunction

	logic                     ext;
	logic                     found;
	logic                     err;
	logic [1:0]               p;
	logic [1:0]               d;
	logic [2:0]               k;
	logic [b2f_pkg::CntW-1:0] c;

	always_comb begin
		res = '0;
		nxt = st;
		ext = st.run_open && (item.base == {1'b0, st.run_nucleotide});
		p = st.flow_position;
		c = st.flow_counter;
		k = '0;
		d = '0;
		found = 1'b0;
		err = 1'b0;
		if (ext) begin
			if (st.run_length != 8'hFF) begin
				nxt.run_length = st.run_length + 8'd1;
			end
		end else begin
			if (st.run_open) begin
				res[0] = b2f_pkg::make_result(c, st.run_nucleotide, st.run_length, 1'b0, 1'b0);
				k = 3'd1;
				p = p + 2'd1;
				c = adv(c);
			end
			for (int i = 3; i >= 0; i--) begin
				if ((i < 3 || !st.run_open) && !item.base[2]
						&& b2f_pkg::order_code(nuc_cycle, p + 2'(i)) == item.base[1:0]) begin
					found = 1'b1;
					d = 2'(i);
				end
			end
			if (!found) begin
				res[k[1:0]] = b2f_pkg::make_result(c, b2f_pkg::order_code(nuc_cycle, p),
					8'd0, 1'b1, 1'b1);
				k = k + 3'd1;
				err = 1'b1;
				nxt = '0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < d) begin
						res[k[1:0]] = b2f_pkg::make_result(c, b2f_pkg::order_code(nuc_cycle, p),
							8'd0, 1'b0, 1'b0);
						k = k + 3'd1;
						p = p + 2'd1;
						c = adv(c);
					end
				end
				nxt.flow_position = p;
				nxt.flow_counter = c;
				nxt.run_nucleotide = item.base[1:0];
				nxt.run_length = 8'd1;
				nxt.run_open = 1'b1;
			end
		end
		if (!err && item.last_of_read) begin
			res[k[1:0]] = b2f_pkg::make_result(nxt.flow_counter, nxt.run_nucleotide,
				nxt.run_length, 1'b0, 1'b1);
			k = k + 3'd1;
			nxt = '0;
		end
		res_cnt = k;
	end

endmodule

`default_nettype wire

@@ design/b2f_queue.sv @@
// ----------------------------------------------------------------------------
// b2f_queue
// Result queue: loads up to four results at once and hands them out one
// transfer per cycle from its head register while the port is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b2f_queue (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 load,
	input  wire  b2f_pkg::result_set_t load_res,
	input  wire  logic [2:0]           load_cnt,
	output logic                       load_ok,
	output logic                       result_valid,
	input  wire  logic                 result_stall,
	output b2f_pkg::result_t           result
);

	b2f_pkg::result_set_t buf_q;
	logic [2:0]           cnt_q;
	logic                 out_xfer;

	assign result_valid = (cnt_q != 3'd0);
	assign result = buf_q[0];
	assign out_xfer = result_valid && !result_stall;
	assign load_ok = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_xfer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_res;
		end else if (out_xfer) begin
			for (int i = 0; i < b2f_pkg::MaxRes - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

@@ design/b2f_check.sv @@
// ----------------------------------------------------------------------------
// b2f_check
// Port-level checks on the result channel of the flowgram encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module b2f_check (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire b2f_pkg::result_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_signal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.flow_signal == {7'd0, result.base_count} * 15'd100)
		else $error("flow signal does not match base count");

	a_bad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_base |-> result.end_of_read)
		else $error("bad base result does not end the read");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_base |-> result.base_count == 8'd0)
		else $error("bad base result carries a count");

endmodule

bind base_to_flowgram_encoder b2f_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire
